FILE: rtl/slc_pkg.sv
// Shared constants, register codes and result type of the LRU cache tag block.
package slc_pkg;

	// default geometry
	localparam int MAX_WAYS     = 8;
	localparam int MAX_SET_BITS = 9;
	localparam int OFFSET_BITS  = 6;

	// fixed field widths
	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 32;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = CFG_IDX_W'(1);

	// register reset values
	localparam logic [CFG_W-1:0] WAYS_RESET     = CFG_W'(1);
	localparam logic [CFG_W-1:0] SET_BITS_RESET = CFG_W'(9);

	// one result beat
	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] miss_count;
		logic [CNT_W-1:0] access_count;
	} slc_result_t;

endpackage

FILE: rtl/slc_fifo.sv
// Small synchronous FIFO used between front and back and on the result side.
module slc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/slc_front.sv
// Front end: config registers and address classification into block, set and ways.
module slc_front #(
	parameter int MAX_WAYS     = slc_pkg::MAX_WAYS,
	parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS,
	parameter int OFFSET_BITS  = slc_pkg::OFFSET_BITS,
	localparam int TAG_W  = slc_pkg::ADDR_W - OFFSET_BITS,
	localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
	localparam int WCNT_W = $clog2(MAX_WAYS + 1),
	localparam int ITEM_W = TAG_W + SET_AW + WCNT_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slc_pkg::CFG_W-1:0]      cfg_data,
	input  logic [slc_pkg::ADDR_W-1:0]     address,
	output logic [ITEM_W-1:0]              item
);

	typedef struct packed {
		logic [TAG_W-1:0]  block;
		logic [SET_AW-1:0] set;
		logic [WCNT_W-1:0] ways;
	} item_t;

	logic [slc_pkg::CFG_W-1:0] ways_q;
	logic [slc_pkg::CFG_W-1:0] set_bits_q;
	item_t                     item_w;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q     <= slc_pkg::WAYS_RESET;
			set_bits_q <= slc_pkg::SET_BITS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				slc_pkg::REG_WAYS_IN_USE:    ways_q     <= cfg_data;
				slc_pkg::REG_SET_INDEX_BITS: set_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		item_w.block = address[slc_pkg::ADDR_W-1:OFFSET_BITS];
		// low set_index_bits of the block number, capped at the store size
		for (int i = 0; i < SET_AW; i++) begin
			item_w.set[i] = item_w.block[i] && (i < MAX_SET_BITS) &&
				(i < int'(set_bits_q));
		end
		if (ways_q == '0) begin
			item_w.ways = WCNT_W'(1);
		end else if (int'(ways_q) > MAX_WAYS) begin
			item_w.ways = WCNT_W'(MAX_WAYS);
		end else begin
			item_w.ways = WCNT_W'(ways_q);
		end
	end

	assign item = item_w;

endmodule

FILE: rtl/slc_back.sv
// Back end: set row memory, LRU update sequencer and saturating counters.
module slc_back #(
	parameter int MAX_WAYS     = slc_pkg::MAX_WAYS,
	parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS,
	parameter int OFFSET_BITS  = slc_pkg::OFFSET_BITS,
	localparam int TAG_W    = slc_pkg::ADDR_W - OFFSET_BITS,
	localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
	localparam int WCNT_W   = $clog2(MAX_WAYS + 1),
	localparam int ITEM_W   = TAG_W + SET_AW + WCNT_W,
	localparam int NUM_SETS = 1 << MAX_SET_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ITEM_W-1:0]    item_in,
	input  logic                 item_empty,
	output logic                 item_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output slc_pkg::slc_result_t res_data,
	output logic                 clearing
);

	typedef struct packed {
		logic [TAG_W-1:0]  block;
		logic [SET_AW-1:0] set;
		logic [WCNT_W-1:0] ways;
	} item_t;

	typedef struct packed {
		logic [MAX_WAYS-1:0]            valid;
		logic [MAX_WAYS-1:0][TAG_W-1:0] tags;
	} row_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CMP,
		ST_WRITE
	} state_t;

	state_t                        state_q;
	logic [SET_AW-1:0]             clr_cnt_q;
	logic [slc_pkg::CNT_W-1:0]     miss_q;
	logic [slc_pkg::CNT_W-1:0]     access_q;

	row_t                          store_q [NUM_SETS];
	row_t                          row_q;
	item_t                         item_w;
	item_t                         item_q;

	// decisions from the compare step
	logic                          hit_q;
	logic                          upd_q;
	logic [WCNT_W-1:0]             lo_q;
	logic [WCNT_W-1:0]             last_q;

	logic                          hit_c;
	logic                          upd_c;
	logic [WCNT_W-1:0]             lo_c;
	logic [WCNT_W-1:0]             last_c;

	logic                          we;
	logic [SET_AW-1:0]             waddr;
	row_t                          wdata;
	row_t                          new_row;
	logic [MAX_WAYS-1:0][TAG_W-1:0] tags_sh;
	logic [slc_pkg::CNT_W-1:0]     miss_nx;
	logic [slc_pkg::CNT_W-1:0]     access_nx;

	assign item_w   = item_in;
	assign clearing = (state_q == ST_CLEAR);
	assign item_pop = (state_q == ST_IDLE) && !item_empty && !res_full;

	// hit lookup and first empty slot among the ways in use
	always_comb begin
		logic [WCNT_W-1:0] fill;
		logic [WCNT_W-1:0] hidx;
		fill  = item_q.ways;
		hidx  = '0;
		hit_c = 1'b0;
		for (int j = MAX_WAYS - 1; j >= 0; j--) begin
			if (WCNT_W'(j) < item_q.ways) begin
				if (!row_q.valid[j]) begin
					fill = WCNT_W'(j);
				end
				if (row_q.valid[j] && row_q.tags[j] == item_q.block) begin
					hit_c = 1'b1;
					hidx  = WCNT_W'(j);
				end
			end
		end
		if (hit_c) begin
			upd_c  = fill > hidx;
			lo_c   = hidx;
			last_c = fill - 1'b1;
		end else if (fill == item_q.ways) begin
			upd_c  = 1'b1;
			lo_c   = '0;
			last_c = item_q.ways - 1'b1;
		end else begin
			upd_c  = 1'b1;
			lo_c   = fill;
			last_c = fill;
		end
	end

	// entries in [lo, last) shift down one way, the block lands at last
	assign tags_sh = row_q.tags >> TAG_W;

	always_comb begin
		new_row = row_q;
		if (upd_q) begin
			for (int j = 0; j < MAX_WAYS; j++) begin
				if (WCNT_W'(j) >= lo_q && WCNT_W'(j) < last_q) begin
					new_row.tags[j]  = tags_sh[j];
					new_row.valid[j] = 1'b1;
				end
				if (WCNT_W'(j) == last_q) begin
					new_row.tags[j]  = item_q.block;
					new_row.valid[j] = 1'b1;
				end
			end
		end
	end

	assign access_nx = (access_q == '1) ? access_q : access_q + 1'b1;
	assign miss_nx   = (hit_q || miss_q == '1) ? miss_q : miss_q + 1'b1;

	assign res_push              = (state_q == ST_WRITE);
	assign res_data.hit          = hit_q;
	assign res_data.miss_count   = miss_nx;
	assign res_data.access_count = access_nx;

	always_comb begin
		we    = 1'b0;
		waddr = item_q.set;
		wdata = new_row;
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = '0;
		end else if (state_q == ST_WRITE) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			miss_q    <= '0;
			access_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == SET_AW'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_pop) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					miss_q   <= miss_nx;
					access_q <= access_nx;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_q <= item_w;
		end
		if (state_q == ST_CMP) begin
			hit_q  <= hit_c;
			upd_q  <= upd_c;
			lo_q   <= lo_c;
			last_q <= last_c;
		end
	end

	// set row memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		if (item_pop) begin
			row_q <= store_q[item_w.set];
		end
	end

endmodule

FILE: rtl/set_assoc_lru_cache_tags.sv
// Top level of the set-associative LRU cache tag block.
// One beat on the input side is one byte address; each one yields exactly one result beat
// with the hit flag and the saturating running miss and access counts, in order. After reset
// the block sweeps all 2**MAX_SET_BITS sets (512 at the defaults) of the set row memory clear,
// one set per cycle; full stays high meanwhile, config writes are still taken. A front
// stage classifies each address (block number, set, effective ways) and queues it; the back
// end handles one address at a time: read of the set row from the single
// row memory, tag compare and LRU decision, then row write-back with the result beat. It
// takes no new address until that read-compare-write loop on the row memory is through, nor
// while the result queue is full. Config (ways_in_use, set_index_bits) is taken from the front
// registers at the time an address is pushed and must only change while the block is idle.
module set_assoc_lru_cache_tags #(
	parameter int MAX_WAYS     = slc_pkg::MAX_WAYS,
	parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS,
	parameter int OFFSET_BITS  = slc_pkg::OFFSET_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [slc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [slc_pkg::CFG_W-1:0]     cfg_data,
	// address in
	input  logic                          push,
	output logic                          full,
	input  logic [slc_pkg::ADDR_W-1:0]    address,
	// results out
	output logic                          empty,
	input  logic                          pop,
	output logic                          hit,
	output logic [slc_pkg::CNT_W-1:0]     miss_count,
	output logic [slc_pkg::CNT_W-1:0]     access_count
);

	localparam int TAG_W  = slc_pkg::ADDR_W - OFFSET_BITS;
	localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int ITEM_W = TAG_W + SET_AW + WCNT_W;
	localparam int RES_W  = $bits(slc_pkg::slc_result_t);

	logic [ITEM_W-1:0]    front_item;
	logic [ITEM_W-1:0]    mid_item;
	logic                 mid_full;
	logic                 mid_empty;
	logic                 mid_pop;
	logic                 clearing;
	logic                 res_full;
	logic                 res_push;
	slc_pkg::slc_result_t res_in;
	slc_pkg::slc_result_t res_out;

	// no address beats while the row memory is being swept
	assign full = mid_full || clearing;

	slc_front #(
		.MAX_WAYS     (MAX_WAYS),
		.MAX_SET_BITS (MAX_SET_BITS),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.address   (address),
		.item      (front_item)
	);

	// classified addresses waiting for the back end
	slc_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (2)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !full),
		.wr_data (front_item),
		.rd_en   (mid_pop),
		.rd_data (mid_item),
		.full    (mid_full),
		.empty   (mid_empty)
	);

	slc_back #(
		.MAX_WAYS     (MAX_WAYS),
		.MAX_SET_BITS (MAX_SET_BITS),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (mid_item),
		.item_empty (mid_empty),
		.item_pop   (mid_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_in),
		.clearing   (clearing)
	);

	// result beats waiting to be popped
	slc_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_out),
		.full    (res_full),
		.empty   (empty)
	);

	assign hit          = res_out.hit;
	assign miss_count   = res_out.miss_count;
	assign access_count = res_out.access_count;

	// back end never pushes a result into a full result queue
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result pushed into full result queue");

	// one address in flight: no back-to-back dispatch
	assert property (@(posedge clk) disable iff (!arst_n) mid_pop |=> !mid_pop)
		else $error("second address dispatched while one is in flight");

	// misses never exceed accesses
	assert property (@(posedge clk) disable iff (!arst_n) !empty |-> access_count >= miss_count)
		else $error("miss count above access count");

	// nothing dispatched during the clearing sweep
	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !mid_pop && !res_push)
		else $error("activity during clearing sweep");

endmodule

FILE: sim/tb.sv
// Testbench for the set-associative LRU cache tag block, with a self-checking LRU predictor.
`timescale 1ns / 100ps

module tb;
	import slc_pkg::*;

	// Geometry of the predictor's copy of the tag store.
	localparam int TAG_W   = ADDR_W - OFFSET_BITS;
	localparam int STORE_N = MAX_WAYS << MAX_SET_BITS;
	localparam int POOL_N  = 32;

	// Register indexes that map to nothing; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	// Receiver behavior: always pop, stall on a fixed pattern, or stall at random.
	typedef enum int {RX_FREE, RX_PATTERN, RX_RANDOM} rx_mode_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic [ADDR_W-1:0]    address = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 hit;
	logic [CNT_W-1:0]     miss_count;
	logic [CNT_W-1:0]     access_count;

	set_assoc_lru_cache_tags uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.address      (address),
		.empty        (empty),
		.pop          (pop),
		.hit          (hit),
		.miss_count   (miss_count),
		.access_count (access_count)
	);

	// ------------------------------------------------------------------
	// Predictor state: valid bits and tags per set row (MAX_WAYS entries
	// per set, LRU first), the two running counters and both registers.
	// ------------------------------------------------------------------
	bit               lru_valid [STORE_N];
	logic [TAG_W-1:0] lru_tag [STORE_N];
	logic [CNT_W-1:0] miss_total;
	logic [CNT_W-1:0] access_total;
	logic [CFG_W-1:0] ways_cfg;
	logic [CFG_W-1:0] set_bits_cfg;

	// Expected result beats, oldest first.
	slc_result_t expected_results[$];

	int       mismatches = 0;
	rx_mode_t rx_mode = RX_FREE;
	int       rx_hold = 0;   // cycles the receiver still holds off
	int       rx_tick = 0;

	// Hot blocks for the random traffic, so that sets see reuse and eviction.
	logic [TAG_W-1:0] block_pool [POOL_N];
	int               pool_used = 1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit: far beyond the slowest correct run (clear pass, ~1240 beats
	// handled one at a time, receiver stalls and the long hold-off).
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// Shift entries from..last-1 down one place and put the tag at last.
	function automatic void place_last(input int base, input int from, input int last,
			input logic [TAG_W-1:0] blk);
		for (int k = from; k < last; k++) begin
			lru_tag[base + k]   = lru_tag[base + k + 1];
			lru_valid[base + k] = 1'b1;
		end
		lru_tag[base + last]   = blk;
		lru_valid[base + last] = 1'b1;
	endfunction

	// One access against the predictor: updates the rows and counters and
	// returns the beat the block has to produce.
	function automatic slc_result_t predict_access(input logic [ADDR_W-1:0] addr);
		int               ways;
		int               sbits;
		int               base;
		int               fill;
		bit               found;
		logic [TAG_W-1:0] blk;
		slc_result_t      res;
		ways  = int'(ways_cfg);
		sbits = int'(set_bits_cfg);
		if (ways == 0) ways = 1;
		if (ways > MAX_WAYS) ways = MAX_WAYS;
		if (sbits > MAX_SET_BITS) sbits = MAX_SET_BITS;
		blk   = addr[ADDR_W-1:OFFSET_BITS];
		base  = (int'(blk) & ((1 << sbits) - 1)) * MAX_WAYS;
		// first free slot; valid ways are packed from position 0
		fill = ways;
		for (int k = 0; k < ways; k++) begin
			if (!lru_valid[base + k]) begin
				fill = k;
				break;
			end
		end
		found = 1'b0;
		for (int k = 0; k < ways; k++) begin
			if (lru_valid[base + k] && lru_tag[base + k] == blk) begin
				found = 1'b1;
				if (fill > k) place_last(base, k, fill - 1, blk);
				break;
			end
		end
		if (access_total != '1) access_total++;
		if (!found) begin
			if (miss_total != '1) miss_total++;
			if (fill == ways) begin
				place_last(base, 0, ways - 1, blk);
			end else begin
				lru_valid[base + fill] = 1'b1;
				lru_tag[base + fill]   = blk;
			end
		end
		res.hit          = found;
		res.miss_count   = miss_total;
		res.access_count = access_total;
		return res;
	endfunction

	// Offer one address; the beat is taken at the edge with push high and full low.
	// push stays high on return so that back-to-back beats need no toggle.
	task automatic send_address(input logic [ADDR_W-1:0] addr);
		push    <= 1'b1;
		address <= addr;
		do @(posedge clk); while (full);
		expected_results.push_back(predict_access(addr));
	endtask

	// One register write beat; cfg_valid is left high for a following write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_WAYS_IN_USE) ways_cfg = data;
		else if (idx == REG_SET_INDEX_BITS) set_bits_cfg = data;
	endtask

	task automatic set_config(input logic [CFG_W-1:0] ways, input logic [CFG_W-1:0] sbits);
		write_reg(REG_WAYS_IN_USE, ways);
		write_reg(REG_SET_INDEX_BITS, sbits);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait until every beat is back and the three-stage back
	// end has settled before the registers change.
	task automatic drain_block();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Hot blocks share a handful of set indexes; the high bits are random.
	task automatic fill_pool(input int n);
		logic [MAX_SET_BITS-1:0] hot [3];
		for (int i = 0; i < 3; i++) hot[i] = MAX_SET_BITS'($urandom);
		pool_used = n;
		for (int i = 0; i < n; i++) begin
			block_pool[i] = TAG_W'($urandom);
			block_pool[i][MAX_SET_BITS-1:0] = hot[$urandom_range(0, 2)];
		end
	endtask

	// Mostly reuse of hot blocks with a random byte offset, some plain noise.
	function automatic logic [ADDR_W-1:0] next_address();
		if ($urandom_range(0, 99) < 85)
			return {block_pool[$urandom_range(0, pool_used - 1)], OFFSET_BITS'($urandom)};
		return $urandom;
	endfunction

	// Bursts of random length with random gaps; some bursts follow straight on.
	task automatic send_traffic(input int n);
		int sent;
		int burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 32);
			for (int i = 0; i < burst && sent < n; i++) begin
				send_address(next_address());
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: one way, nine set bits. First beats wait out the clear pass.
	// Covers the all-zero and all-one addresses and offset bits being ignored.
	task automatic test_reset_defaults();
		rx_mode = RX_FREE;
		send_address(32'h0000_0000);   // cold miss
		send_address(32'h0000_003F);   // same block, hit
		send_address(32'hFFFF_FFFF);   // top set, miss
		send_address(32'hFFFF_FFC0);   // same block, hit
		send_address(32'h0000_8000);   // aliases set 0, evicts block 0
		send_address(32'h0000_0000);   // block 0 is gone again
		drain_block();
	endtask

	// One set, four ways: fill, hit moves to MRU, miss on a full set evicts LRU.
	task automatic test_lru_order();
		set_config(CFG_W'(4), CFG_W'(0));
		rx_mode = RX_PATTERN;
		send_address(32'h0000_0040);   // A
		send_address(32'h0000_0080);   // B
		send_address(32'h0000_00C0);   // C
		send_address(32'h0000_0100);   // D, set now full
		send_address(32'h0000_0040);   // A hit, order B C D A
		send_address(32'h0000_0140);   // E evicts B
		send_address(32'h0000_0080);   // B miss, evicts C
		send_address(32'h0000_00C0);   // C miss, evicts D
		drain_block();
	endtask

	// Out-of-range register values: zero ways acts as one, above max saturates.
	task automatic test_register_limits();
		set_config(CFG_W'(0), CFG_W'(15));
		send_address(32'h0000_0040);
		send_address(32'h0000_0040);
		send_address(32'h0000_8040);   // same set at nine bits, single way evicts
		drain_block();
		set_config(CFG_W'(15), CFG_W'(0));
		send_address(32'hFFFF_FFC0);
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		drain_block();
	endtask

	// Writes to unmapped indexes leave both registers as they are.
	task automatic test_spare_index();
		write_reg(REG_SPARE_A, CFG_W'(0));
		write_reg(REG_SPARE_B, CFG_W'(15));
		cfg_valid <= 1'b0;
		send_address(32'h0000_0000);
		send_address(32'h1234_5678);
		drain_block();
	endtask

	// Receiver holds off for a long stretch while the sender keeps pushing:
	// the block backs up and must stall its input without losing beats.
	task automatic test_backpressure();
		set_config(CFG_W'(2), CFG_W'(2));
		fill_pool(8);
		rx_mode = RX_FREE;
		rx_hold = 400;
		for (int i = 0; i < 60; i++) send_address(next_address());
		drain_block();
	endtask

	// Random traffic over several register settings, extremes included.
	task automatic test_random_traffic();
		logic [CFG_W-1:0] ways_set [8];
		logic [CFG_W-1:0] sbits_set [8];
		int               ways_eff;
		ways_set  = '{CFG_W'(1), CFG_W'(8), CFG_W'(2), CFG_W'(4), CFG_W'(0), CFG_W'(15),
			CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(0, 15))};
		sbits_set = '{CFG_W'(9), CFG_W'(0), CFG_W'(1), CFG_W'(3), CFG_W'(12), CFG_W'(9),
			CFG_W'($urandom_range(0, 9)), CFG_W'($urandom_range(0, 15))};
		for (int p = 0; p < 8; p++) begin
			set_config(ways_set[p], sbits_set[p]);
			ways_eff = (ways_set[p] == 0) ? 1 :
				(ways_set[p] > MAX_WAYS) ? MAX_WAYS : int'(ways_set[p]);
			fill_pool((3 * ways_eff + 3 < POOL_N) ? 3 * ways_eff + 3 : POOL_N);
			rx_mode = rx_mode_t'(p % 3);
			send_traffic(145);
			drain_block();
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: pop pattern, plus the long hold-off counted here.
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			rx_tick++;
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE:    pop <= 1'b1;
					RX_PATTERN: pop <= !((rx_tick % 5) == 0 || (rx_tick % 11) < 3);
					default:    pop <= ($urandom_range(0, 99) < 60);
				endcase
			end
		end
	end

	// Result checker: every popped beat against the oldest expectation.
	always @(posedge clk) begin
		slc_result_t exp_beat;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result beat: hit=%0b miss=%0d access=%0d",
						hit, miss_count, access_count);
				mismatches++;
			end else begin
				exp_beat = expected_results.pop_front();
				if (hit !== exp_beat.hit || miss_count !== exp_beat.miss_count ||
						access_count !== exp_beat.access_count) begin
					if (mismatches < 10)
						$display("mismatch: expected hit=%0b miss=%0d access=%0d, %s",
							exp_beat.hit, exp_beat.miss_count, exp_beat.access_count,
							$sformatf("got hit=%0b miss=%0d access=%0d",
								hit, miss_count, access_count));
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int wait_cycles;
		// predictor matches the block after reset
		for (int i = 0; i < STORE_N; i++) begin
			lru_valid[i] = 1'b0;
			lru_tag[i]   = '0;
		end
		miss_total   = '0;
		access_total = '0;
		ways_cfg     = WAYS_RESET;
		set_bits_cfg = SET_BITS_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_lru_order();
		test_register_limits();
		test_spare_index();
		test_backpressure();
		test_random_traffic();

		// final drain, bounded; anything still expected afterwards is a failure
		push <= 1'b0;
		rx_mode = RX_FREE;
		wait_cycles = 0;
		while (expected_results.size() != 0 && wait_cycles < 50000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0d expected result beats never arrived", expected_results.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
